// ===== hdl/annexb_pkg.sv =====
package annexb_pkg;

    localparam int unsigned WIN_DEPTH = 5;
    localparam int unsigned FILL_W    = $clog2(WIN_DEPTH + 1);

    localparam logic [2:0] CLASS_OTHER   = 3'd0;
    localparam logic [2:0] CLASS_PARAM   = 3'd1;
    localparam logic [2:0] CLASS_SEI     = 3'd2;
    localparam logic [2:0] CLASS_KEY     = 3'd3;
    localparam logic [2:0] CLASS_NON_KEY = 3'd4;

    localparam logic MODE_H264 = 1'b0;
    localparam logic MODE_H265 = 1'b1;

    localparam logic [7:0] H264_SPS     = 8'h67;
    localparam logic [7:0] H264_PPS     = 8'h68;
    localparam logic [7:0] H264_SEI     = 8'h06;
    localparam logic [7:0] H264_IDR     = 8'h65;
    localparam logic [7:0] H264_NON_IDR = 8'h61;

    localparam logic [7:0] H265_VPS     = 8'h40;
    localparam logic [7:0] H265_SPS     = 8'h42;
    localparam logic [7:0] H265_PPS     = 8'h44;
    localparam logic [7:0] H265_SEI     = 8'h4e;
    localparam logic [7:0] H265_IDR     = 8'h26;
    localparam logic [7:0] H265_TRAIL   = 8'h02;

    localparam logic [7:0] CODE_ZERO = 8'h00;
    localparam logic [7:0] CODE_ONE  = 8'h01;

    typedef struct packed {
        logic       full;
        logic       start;
        logic [7:0] oldest_byte;
        logic [7:0] header_byte;
    } win_status_t;

    function automatic logic [2:0] classify(input logic [7:0] hdr, input logic mode);
        logic [2:0] cls;
        cls = CLASS_OTHER;
        if (mode == MODE_H265)
        begin
            case (hdr) inside
                H265_VPS, H265_SPS, H265_PPS: cls = CLASS_PARAM;
                H265_SEI:                     cls = CLASS_SEI;
                H265_IDR:                     cls = CLASS_KEY;
                H265_TRAIL:                   cls = CLASS_NON_KEY;
                default:                      cls = CLASS_OTHER;
            endcase
        end
        else
        begin
            case (hdr) inside
                H264_SPS, H264_PPS: cls = CLASS_PARAM;
                H264_SEI:           cls = CLASS_SEI;
                H264_IDR:           cls = CLASS_KEY;
                H264_NON_IDR:       cls = CLASS_NON_KEY;
                default:            cls = CLASS_OTHER;
            endcase
        end
        return cls;
    endfunction

endpackage

// ===== hdl/annexb_in_if.sv =====
interface annexb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

// ===== hdl/annexb_out_if.sv =====
interface annexb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       unit_start;
    logic [2:0] unit_class;
    logic [7:0] header_byte;

    modport source (
        output valid, output out_byte, output unit_start, output unit_class,
        output header_byte, input ready
    );
    modport sink (
        input valid, input out_byte, input unit_start, input unit_class,
        input header_byte, output ready
    );
endinterface

// ===== hdl/annexb_window.sv =====
module annexb_window (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    shift_en,
    input  logic [7:0]              in_byte,
    input  logic                    codec_mode,
    output annexb_pkg::win_status_t status
);
    import annexb_pkg::*;

    logic [7:0]        win_reg [WIN_DEPTH];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              full;

    assign full = (fill_reg == FILL_W'(WIN_DEPTH));

    // Shifting in at the young end during the fill leaves the bytes in arrival
    // order once the window is full, so one shift path serves both phases.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                win_reg[i] <= CODE_ZERO;
            end
        end
        else if (shift_en)
        begin
            for (int i = 0; i < WIN_DEPTH - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WIN_DEPTH-1] <= in_byte;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (shift_en && !full)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_comb
    begin
        status.full        = full;
        status.oldest_byte = win_reg[0];
        status.header_byte = win_reg[4];
        status.start       = full && (win_reg[0] == CODE_ZERO) && (win_reg[1] == CODE_ZERO)
                             && (win_reg[2] == CODE_ZERO) && (win_reg[3] == CODE_ONE)
                             && ((codec_mode == MODE_H264) || (in_byte == CODE_ONE));
    end

endmodule

// ===== hdl/annexb_nal_unit_splitter.sv =====
// Channel   Dir   Payload                                          Handshake
// in_ch     in    in_byte                                          valid/ready
// out_ch    out   out_byte, unit_start, unit_class, header_byte    valid/ready
// cfg       in    cfg_wdata (codec_mode)                           cfg_we
//
// One byte is taken per clock while no result is stalled; a result is registered
// in the output register as the byte that releases it is taken, five bytes behind the stream.
// The first five bytes after reset only fill the window and give no result.
// Reset is asynchronous and active low, and clears the window and unit state.
// The input stalls only while a result waits in the output register and the
// sink is not ready.
module annexb_nal_unit_splitter (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    annexb_in_if.sink    in_ch,
    annexb_out_if.source out_ch
);
    import annexb_pkg::*;

    win_status_t win;
    logic        accept;
    logic        emit;

    logic        codec_mode_reg;
    logic        inside_reg;
    logic        inside_next;
    logic [2:0]  class_reg;
    logic [2:0]  class_next;
    logic [7:0]  header_reg;
    logic [7:0]  header_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_start_reg;
    logic [2:0]  out_class_reg;
    logic [7:0]  out_header_reg;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    annexb_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (accept),
        .in_byte    (in_ch.in_byte),
        .codec_mode (codec_mode_reg),
        .status     (win)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_mode_reg <= MODE_H264;
        end
        else if (cfg_we)
        begin
            codec_mode_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        inside_next = inside_reg;
        class_next  = class_reg;
        header_next = header_reg;
        if (accept && win.start)
        begin
            inside_next = 1'b1;
            header_next = win.header_byte;
            class_next  = classify(win.header_byte, codec_mode_reg);
        end
    end

    assign emit = accept && win.full && inside_next;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg    <= 1'b0;
            class_reg     <= CLASS_OTHER;
            header_reg    <= CODE_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            inside_reg    <= inside_next;
            class_reg     <= class_next;
            header_reg    <= header_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg   <= win.oldest_byte;
            out_start_reg  <= win.start;
            out_class_reg  <= class_next;
            out_header_reg <= header_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_byte    = out_byte_reg;
    assign out_ch.unit_start  = out_start_reg;
    assign out_ch.unit_class  = out_class_reg;
    assign out_ch.header_byte = out_header_reg;

    // Nothing leaves the block before the first start code has been seen.
    a_no_result_before_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !inside_reg |-> !out_valid_reg)
        else $error("result present before the first start code");

    // A unit always opens on the first zero byte of its start code.
    a_start_on_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_start_reg) |-> (out_byte_reg == CODE_ZERO))
        else $error("unit start flagged on a non-zero byte");

    // The header carried by a unit's first byte is the one held for the unit.
    a_header_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_start_reg) |-> (out_header_reg == header_reg))
        else $error("unit header differs from the held header");

    // A pending result that is not taken blocks further input.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |-> !accept)
        else $error("item accepted while a result is stalled");

    // A result that was stalled is still there on the next edge.
    a_stalled_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> out_valid_reg)
        else $error("stalled result lost");

endmodule

// ===== tb/sv/annexb_nal_unit_splitter_tb.sv =====
`timescale 1ns / 1ps

module annexb_nal_unit_splitter_tb;

    import annexb_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic [2:0] cls;
        logic [7:0] hdr;
    } nal_byte_t;

    // Tracks the splitter's window and unit state, and holds the output bytes still due.
    class nal_stream_tracker;
        logic [7:0]  window [WIN_DEPTH];
        int unsigned fill;
        logic        in_unit;
        logic [2:0]  unit_cls;
        logic [7:0]  unit_hdr;
        logic        mode;
        nal_byte_t   due_bytes [$];
        int unsigned errors;

        function new();
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                window[i] = CODE_ZERO;
            end
            fill = 0;
            in_unit = 1'b0;
            unit_cls = CLASS_OTHER;
            unit_hdr = CODE_ZERO;
            mode = MODE_H264;
            errors = 0;
        endfunction

        function logic [2:0] class_of(logic [7:0] h, logic m);
            if (m == MODE_H265)
            begin
                if (h == H265_VPS || h == H265_SPS || h == H265_PPS)
                    return CLASS_PARAM;
                if (h == H265_SEI)
                    return CLASS_SEI;
                if (h == H265_IDR)
                    return CLASS_KEY;
                if (h == H265_TRAIL)
                    return CLASS_NON_KEY;
                return CLASS_OTHER;
            end
            if (h == H264_SPS || h == H264_PPS)
                return CLASS_PARAM;
            if (h == H264_SEI)
                return CLASS_SEI;
            if (h == H264_IDR)
                return CLASS_KEY;
            if (h == H264_NON_IDR)
                return CLASS_NON_KEY;
            return CLASS_OTHER;
        endfunction

        function void set_mode(logic m);
            mode = m;
        endfunction

        function void note_byte(logic [7:0] b);
            logic      found;
            nal_byte_t item;
            if (fill < WIN_DEPTH)
            begin
                window[fill] = b;
                fill++;
                return;
            end
            found = window[0] == CODE_ZERO && window[1] == CODE_ZERO &&
                    window[2] == CODE_ZERO && window[3] == CODE_ONE &&
                    (mode == MODE_H264 || b == CODE_ONE);
            if (found)
            begin
                in_unit = 1'b1;
                unit_hdr = window[4];
                unit_cls = class_of(window[4], mode);
            end
            if (in_unit)
            begin
                item.data = window[0];
                item.first = found;
                item.cls = unit_cls;
                item.hdr = unit_hdr;
                due_bytes.push_back(item);
            end
            for (int i = 0; i < WIN_DEPTH - 1; i++)
            begin
                window[i] = window[i + 1];
            end
            window[WIN_DEPTH - 1] = b;
        endfunction

        function void check_result(nal_byte_t got);
            nal_byte_t want;
            if (due_bytes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output byte %h start %b class %0d header %h",
                         $time, got.data, got.first, got.cls, got.hdr);
                return;
            end
            want = due_bytes.pop_front();
            if (got.data !== want.data || got.first !== want.first ||
                got.cls !== want.cls || got.hdr !== want.hdr)
            begin
                errors++;
                $display("%0t: mismatch, expected %h/%b/%0d/%h, got %h/%b/%0d/%h",
                         $time, want.data, want.first, want.cls, want.hdr,
                         got.data, got.first, got.cls, got.hdr);
            end
        endfunction

        function int unsigned outstanding();
            return due_bytes.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    annexb_in_if  in_ch ();
    annexb_out_if out_ch ();

    annexb_nal_unit_splitter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    nal_stream_tracker tracker = new();

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_token;
    int unsigned bytes_sent;
    logic        gen_mode;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: random back-pressure, plus a long hold-off when one is requested.
    initial
    begin
        int unsigned hold_seen;
        int unsigned stall_left;
        hold_seen = 0;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                stall_left = 300;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready = 1'b0;
            end
            else
                out_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        nal_byte_t got;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.data = out_ch.out_byte;
                got.first = out_ch.unit_start;
                got.cls = out_ch.unit_class;
                got.hdr = out_ch.header_byte;
                tracker.check_result(got);
            end
            if (in_ch.valid && in_ch.ready)
                tracker.note_byte(in_ch.in_byte);
            if (cfg_we)
                tracker.set_mode(cfg_wdata);
        end
    end

    // Called at a falling edge; returns at the falling edge after the byte was taken.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.in_byte = b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_bytes(input logic [8*32-1:0] seq, input int unsigned n);
        for (int i = n - 1; i >= 0; i--)
        begin
            send_byte(seq[i*8 +: 8]);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (tracker.outstanding() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_we = 1'b1;
        cfg_wdata = m;
        gen_mode = m;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [7:0] pick_header();
        case ($urandom_range(0, 13))
            0: return H264_SPS;
            1: return H264_PPS;
            2: return H264_SEI;
            3: return H264_IDR;
            4: return H264_NON_IDR;
            5: return H265_VPS;
            6: return H265_SPS;
            7: return H265_PPS;
            8: return H265_SEI;
            9: return H265_IDR;
            10: return H265_TRAIL;
            11: return CODE_ZERO;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_unit();
        int unsigned len;
        repeat (3) send_byte(CODE_ZERO);
        send_byte(CODE_ONE);
        send_byte(pick_header());
        // In H.265 mode an occasional wrong second header byte gives a near-miss.
        if (gen_mode == MODE_H265)
            send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : CODE_ONE);
        if ($urandom_range(0, 9) == 0)
            len = $urandom_range(20, 60);
        else
            len = $urandom_range(0, 12);
        repeat (len)
        begin
            send_byte(($urandom_range(0, 3) == 0) ? CODE_ZERO : 8'($urandom));
        end
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0:
            begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
            1:
            begin
                repeat (2) send_byte(CODE_ZERO);
                send_byte(CODE_ONE);
                send_byte(8'($urandom));
            end
            default:
            begin
                repeat (3) send_byte(CODE_ZERO);
                send_byte(8'($urandom_range(2, 255)));
            end
        endcase
    endtask

    task automatic send_stream(input int unsigned count);
        int unsigned target;
        target = bytes_sent + count;
        while (bytes_sent < target)
        begin
            if ($urandom_range(0, 99) < 15)
                send_noise();
            else
                send_unit();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = MODE_H264;
        in_ch.valid = 1'b0;
        in_ch.in_byte = 8'h00;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_token = 0;
        bytes_sent = 0;
        gen_mode = MODE_H264;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // No idling: window fill, bytes dropped before the first start, and each H.264 class.
        write_mode(MODE_H264);
        send_bytes({8'hFF, CODE_ZERO, CODE_ZERO, CODE_ZERO, CODE_ZERO, CODE_ONE,
                    H264_IDR, 8'hFF, CODE_ZERO, CODE_ZERO, CODE_ZERO, CODE_ONE,
                    H264_SEI, 8'h80, CODE_ZERO, CODE_ZERO, CODE_ZERO, CODE_ONE,
                    H264_NON_IDR, CODE_ZERO, CODE_ZERO, CODE_ZERO, CODE_ONE,
                    H264_SPS, 8'h7F}, 25);
        send_stream(250);
        wait_drained();

        // Sender idling, H.265 rules with a near-miss, and a long receiver hold-off.
        write_mode(MODE_H265);
        send_idle_pct = 50;
        recv_stall_pct = 0;
        send_bytes({CODE_ZERO, CODE_ZERO, CODE_ZERO, CODE_ONE, H265_IDR, H265_TRAIL,
                    8'hFF, CODE_ZERO, CODE_ZERO, CODE_ZERO, CODE_ONE, H265_SEI,
                    CODE_ONE, 8'hAA, CODE_ZERO, CODE_ZERO, CODE_ZERO, CODE_ONE,
                    H265_VPS, CODE_ONE, CODE_ZERO}, 21);
        hold_token++;
        send_stream(280);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 50;
        write_mode(MODE_H264);
        send_stream(280);
        wait_drained();

        send_idle_pct = 17;
        recv_stall_pct = 17;
        write_mode(MODE_H265);
        send_stream(280);

        wait_drained();
        repeat (10) @(negedge clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
